/* hw/rtl/floor_ray_texture_sampler_macros.svh */
// assertion macros for the floor ray texture sampler
`ifndef FLOOR_RAY_TEXTURE_SAMPLER_MACROS_SVH
`define FLOOR_RAY_TEXTURE_SAMPLER_MACROS_SVH
`ifndef SYNTHESIS
`define FRAY_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FRAY_ASSERT_IMPL(lbl, pre, post, msg) \
  `FRAY_ASSERT(lbl, (pre) |-> (post), msg)
`else
`define FRAY_ASSERT(lbl, prop, msg)
`define FRAY_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

/* hw/rtl/fray_pkg.sv */
package fray_pkg;

  localparam int TexMaxWidth  = 256;
  localparam int TexMaxHeight = 256;
  localparam int MaxFrameDim  = 4096;
  localparam int StoreDepth   = 65536;
  localparam int TexIdxW      = 16;
  localparam int ColorW       = 24;
  localparam int PixW         = 12;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 64;
  localparam int DivSteps     = 31;
  localparam int ModSteps     = 24;

  localparam logic [ColorW-1:0] SkyColor = 24'hADD8E6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRotZero  = 3'd0,
    CfgRotOne   = 3'd1,
    CfgRotTwo   = 3'd2,
    CfgCamXy    = 3'd3,
    CfgCamZ     = 3'd4,
    CfgFocal    = 3'd5,
    CfgFrame    = 3'd6,
    CfgTexSize  = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    ActWrite  = 1'b0,
    ActRender = 1'b1
  } action_e;

  typedef struct packed {
    logic               v;
    action_e            act;
    logic               sky;
    logic [TexIdxW-1:0] tidx;
    logic [ColorW-1:0]  tcol;
  } ctl_t;

endpackage

/* hw/rtl/fray_ram.sv */
module fray_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/floor_ray_texture_sampler.sv */
// channel   direction  transfer when              payload
// in        to block   in_valid_i & !in_stall_o   action, texel index/color, pixel x/y
// out       from block out_valid_o & !out_stall_i color, is_sky
// cfg       to block   cfg_valid_i & cfg_ready_o  register index, write data
//
// one item per clock unless a stalled result holds the pipeline
// most of the pipeline is the 31-stage restoring divider for the ray parameter and the
// 24-stage remainder pipeline for the texture row
// reset clears all valid bits and the pipeline registers; the texture store is not cleared
// a stalled result freezes every stage and the texture store read register
`include "floor_ray_texture_sampler_macros.svh"

module floor_ray_texture_sampler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [fray_pkg::TexIdxW-1:0]    texel_index_i,
  input  logic [fray_pkg::ColorW-1:0]     texel_color_i,
  input  logic [fray_pkg::PixW-1:0]       pixel_x_i,
  input  logic [fray_pkg::PixW-1:0]       pixel_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fray_pkg::ColorW-1:0]     color_o,
  output logic                            is_sky_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fray_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [fray_pkg::CfgDataW-1:0]   cfg_data_i
);
  import fray_pkg::*;

  typedef struct packed {
    ctl_t        c;
    logic [49:0] r;
    logic [30:0] q;
    logic [33:0] d;
    logic        ovf;
    logic [33:0] mx;
    logic [33:0] my;
    logic        nx;
    logic        ny;
  } div_t;

  typedef struct packed {
    ctl_t        c;
    logic [47:0] xl;
    logic [47:0] xh;
    logic [47:0] yl;
    logic [47:0] yh;
    logic        nx;
    logic        ny;
  } mul_t;

  typedef struct packed {
    ctl_t               c;
    logic signed [32:0] sx;
    logic signed [32:0] sy;
  } off_t;

  typedef struct packed {
    ctl_t               c;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
  } wld_t;

  typedef struct packed {
    ctl_t        c;
    logic [8:0]  tx;
    logic [23:0] mag;
    logic [8:0]  r;
    logic        neg;
  } mod_t;

  typedef struct packed {
    ctl_t               c;
    logic signed [16:0] u;
    logic signed [16:0] v;
  } ray_t;

  function automatic logic [33:0] mag34(input logic signed [34:0] d);
    logic signed [34:0] n;
    n = -d;
    return d[34] ? n[33:0] : d[33:0];
  endfunction

  function automatic logic signed [32:0] offs(input logic [47:0] lo, input logic [47:0] hi,
                                              input logic neg);
    logic [64:0]        p;
    logic [46:0]        o;
    logic [31:0]        oc;
    logic signed [32:0] x;
    p  = {hi, 17'b0} + 65'(lo);
    o  = p[64:18];
    oc = (o > 47'h80000000) ? 32'h80000000 : o[31:0];
    x  = $signed({1'b0, oc});
    if (neg) begin
      return -x;
    end
    return (oc > 32'h7FFFFFFF) ? 33'sh07FFFFFFF : x;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [31:0] cam,
                                               input logic signed [32:0] s);
    logic signed [33:0] sum;
    sum = 34'(cam) + 34'(s);
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      return sum[31:0];
    end
    return sum[33] ? 32'sh80000000 : 32'sh7FFFFFFF;
  endfunction

  // configuration registers
  logic [47:0] rot_q [3];
  logic [63:0] cam_xy_q;
  logic [31:0] cam_z_q;
  logic [15:0] focal_q;
  logic [23:0] frame_q;
  logic [17:0] tex_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= 48'h000000004000;
      rot_q[1] <= 48'h000040000000;
      rot_q[2] <= 48'h400000000000;
      cam_xy_q <= '0;
      cam_z_q  <= 32'hFFFF0000;
      focal_q  <= 16'd8000;
      frame_q  <= 24'h1E0280;
      tex_q    <= 18'h20100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgRotZero: rot_q[0] <= cfg_data_i[47:0];
        CfgRotOne:  rot_q[1] <= cfg_data_i[47:0];
        CfgRotTwo:  rot_q[2] <= cfg_data_i[47:0];
        CfgCamXy:   cam_xy_q <= cfg_data_i;
        CfgCamZ:    cam_z_q  <= cfg_data_i[31:0];
        CfgFocal:   focal_q  <= cfg_data_i[15:0];
        CfgFrame:   frame_q  <= cfg_data_i[23:0];
        CfgTexSize: tex_q    <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // derived configuration
  logic [12:0]        frame_w, frame_h;
  logic [8:0]         cols, rows;
  logic signed [31:0] cz;
  logic [31:0]        cz_mag;

  always_comb begin
    frame_w = {1'b0, frame_q[11:0]};
    frame_h = {1'b0, frame_q[23:12]};
    if (frame_w > 13'(MaxFrameDim)) frame_w = 13'(MaxFrameDim);
    if (frame_h > 13'(MaxFrameDim)) frame_h = 13'(MaxFrameDim);
    cols = tex_q[8:0];
    rows = tex_q[17:9];
    if (cols == 9'd0) cols = 9'd1;
    if (rows == 9'd0) rows = 9'd1;
    if (cols > 9'(TexMaxWidth)) cols = 9'(TexMaxWidth);
    if (rows > 9'(TexMaxHeight)) rows = 9'(TexMaxHeight);
    cz     = $signed(cam_z_q);
    cz_mag = cz[31] ? 32'(-cz) : cam_z_q;
  end

  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ray forming
  ray_t               ray_d, ray_q;
  logic signed [13:0] diff_x, diff_y;

  always_comb begin
    diff_x       = $signed({1'b0, pixel_x_i, 1'b0}) - $signed({1'b0, frame_w});
    diff_y       = $signed({1'b0, pixel_y_i, 1'b0}) - $signed({1'b0, frame_h});
    ray_d.c.v    = in_valid_i;
    ray_d.c.act  = action_e'(action_i);
    ray_d.c.sky  = 1'b0;
    ray_d.c.tidx = texel_index_i;
    ray_d.c.tcol = texel_color_i;
    ray_d.u      = {diff_x, 3'b000};
    ray_d.v      = {diff_y, 3'b000};
  end

  // rotation products
  ctl_t               c2_q;
  logic signed [32:0] prod_d [9];
  logic signed [32:0] prod_q [9];
  logic signed [16:0] opnd [3];

  always_comb begin
    opnd[0] = ray_q.u;
    opnd[1] = ray_q.v;
    opnd[2] = $signed({1'b0, focal_q});
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[3*r+j] = $signed(rot_q[r][16*j +: 16]) * opnd[j];
      end
    end
  end

  // rotated ray sums
  ctl_t               c3_q;
  logic signed [34:0] dir_d [3];
  logic signed [34:0] dir_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dir_d[r] = 35'(prod_q[3*r]) + 35'(prod_q[3*r+1]) + 35'(prod_q[3*r+2]);
    end
  end

  // divider setup and restoring divider steps
  div_t        div_d [DivSteps+1];
  div_t        div_q [DivSteps+1];
  div_t        dsrc;
  logic [63:0] dsh;

  always_comb begin
    div_d[0].c     = c3_q;
    div_d[0].c.sky = (dir_q[2] == '0) || (cz == '0) || ((dir_q[2] > 0) == (cz > 0));
    div_d[0].r     = {cz_mag, 18'b0};
    div_d[0].q     = '0;
    div_d[0].d     = mag34(dir_q[2]);
    div_d[0].ovf   = {15'b0, cz_mag, 18'b0} >= {mag34(dir_q[2]), 31'b0};
    div_d[0].mx    = mag34(dir_q[0]);
    div_d[0].my    = mag34(dir_q[1]);
    div_d[0].nx    = dir_q[0][34];
    div_d[0].ny    = dir_q[1][34];
    dsrc           = div_q[0];
    dsh            = '0;
    for (int k = 1; k <= DivSteps; k++) begin
      dsrc     = div_q[k-1];
      div_d[k] = dsrc;
      dsh      = 64'(dsrc.d) << (DivSteps - k);
      if (64'(dsrc.r) >= dsh) begin
        div_d[k].r                    = dsrc.r - dsh[49:0];
        div_d[k].q[5'(DivSteps - k)]  = 1'b1;
      end
    end
  end

  // offset partial products
  mul_t        mul_d, mul_q;
  logic [30:0] tpar;
  div_t        dend;

  always_comb begin
    dend     = div_q[DivSteps];
    tpar     = dend.ovf ? 31'h7FFFFFFF : dend.q;
    mul_d.c  = dend.c;
    mul_d.xl = tpar * dend.mx[16:0];
    mul_d.xh = tpar * dend.mx[33:17];
    mul_d.yl = tpar * dend.my[16:0];
    mul_d.yh = tpar * dend.my[33:17];
    mul_d.nx = dend.nx;
    mul_d.ny = dend.ny;
  end

  off_t off_d, off_q;
  wld_t wld_d, wld_q;

  always_comb begin
    off_d.c  = mul_q.c;
    off_d.sx = offs(mul_q.xl, mul_q.xh, mul_q.nx);
    off_d.sy = offs(mul_q.yl, mul_q.yh, mul_q.ny);
    wld_d.c  = off_q.c;
    wld_d.wx = sat32($signed(cam_xy_q[31:0]), off_q.sx);
    wld_d.wy = sat32($signed(cam_xy_q[63:32]), off_q.sy);
  end

  // texture coordinates and row remainder steps
  mod_t               mod_d [ModSteps+1];
  mod_t               mod_q [ModSteps+1];
  mod_t               msrc;
  logic [24:0]        txp;
  logic signed [41:0] nprod;
  logic signed [25:0] nrow;
  logic [9:0]         rr;

  always_comb begin
    txp            = wld_q.wx[15:0] * cols;
    nprod          = wld_q.wy * $signed({1'b0, cols});
    nrow           = nprod[41:16];
    mod_d[0].c     = wld_q.c;
    mod_d[0].tx    = txp[24:16];
    mod_d[0].neg   = nrow[25];
    mod_d[0].mag   = nrow[25] ? 24'(-nrow) : nrow[23:0];
    mod_d[0].r     = '0;
    msrc           = mod_q[0];
    rr             = '0;
    for (int k = 1; k <= ModSteps; k++) begin
      msrc     = mod_q[k-1];
      mod_d[k] = msrc;
      rr       = {msrc.r, msrc.mag[5'(ModSteps - k)]};
      if (rr >= {1'b0, rows}) begin
        rr = rr - {1'b0, rows};
      end
      mod_d[k].r = rr[8:0];
    end
  end

  // texel address and store access
  mod_t                    fin;
  logic [8:0]              tx_c, ty_raw, ty_c;
  logic [TexIdxW-1:0]      ram_addr;
  logic                    ram_we;
  logic [ColorW-1:0]       ram_rdata;
  ctl_t                    g_q;

  always_comb begin
    fin    = mod_q[ModSteps];
    ty_raw = (fin.neg && fin.r != 9'd0) ? rows - fin.r : fin.r;
    ty_c   = (ty_raw > rows - 9'd1) ? rows - 9'd1 : ty_raw;
    tx_c   = (fin.tx > cols - 9'd1) ? cols - 9'd1 : fin.tx;
    if (fin.c.act == ActWrite) begin
      ram_addr = fin.c.tidx;
    end else begin
      ram_addr = TexIdxW'(32'(ty_c) * TexMaxWidth + 32'(tx_c));
    end
    ram_we = en && fin.c.v && fin.c.act == ActWrite;
  end

  fray_ram #(
    .Width (ColorW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (fin.c.tcol),
    .rdata_o (ram_rdata)
  );

  // pipeline registers
  logic [ColorW-1:0] color_q;
  logic              is_sky_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_q       <= '0;
      c2_q        <= '0;
      c3_q        <= '0;
      mul_q       <= '0;
      off_q       <= '0;
      wld_q       <= '0;
      g_q         <= '0;
      out_valid_q <= 1'b0;
      is_sky_q    <= 1'b0;
      color_q     <= '0;
      for (int k = 0; k <= DivSteps; k++) begin
        div_q[k] <= '0;
      end
      for (int k = 0; k <= ModSteps; k++) begin
        mod_q[k] <= '0;
      end
      for (int i = 0; i < 9; i++) begin
        prod_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        dir_q[i] <= '0;
      end
    end else if (en) begin
      ray_q  <= ray_d;
      c2_q   <= ray_q.c;
      prod_q <= prod_d;
      c3_q   <= c2_q;
      dir_q  <= dir_d;
      div_q  <= div_d;
      mul_q  <= mul_d;
      off_q  <= off_d;
      wld_q  <= wld_d;
      mod_q  <= mod_d;
      g_q    <= fin.c;
      out_valid_q <= g_q.v && g_q.act == ActRender;
      is_sky_q    <= g_q.sky;
      color_q     <= g_q.sky ? SkyColor : ram_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_sky_o    = is_sky_q;
  assign color_o     = color_q;

  `FRAY_ASSERT_IMPL(a_stall_chain, out_valid_o && out_stall_i, in_stall_o, "stall not passed to input")
  `FRAY_ASSERT_IMPL(a_sky_color, out_valid_o && is_sky_o, color_o == SkyColor, "sky result with texel color")
  `FRAY_ASSERT_IMPL(a_row_range, fin.c.v && fin.c.act == ActRender, ty_raw < rows, "texture row out of range")
  `FRAY_ASSERT_IMPL(a_col_range, fin.c.v && fin.c.act == ActRender, fin.tx < cols, "texture column out of range")
  `FRAY_ASSERT(a_write_silent, g_q.v && g_q.act == ActWrite && en |=> !out_valid_o, "texel write made a result")

endmodule
